// ----- src/lrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Shared constants, opcodes and controller command type for the LRU
// register selector. Used by the controller, the datapath and the top level.
package lrs_pkg;

    localparam int NUM_REGS = 16;
    localparam int ENTRY_W  = (NUM_REGS > 2) ? $clog2(NUM_REGS) : 1;
    localparam int ID_W     = 4;
    localparam int OP_W     = 2;
    localparam int CMP_W    = (ENTRY_W > ID_W) ? ENTRY_W : ID_W;

    localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
    localparam logic [OP_W-1:0] OP_TOUCH = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 2'd2;

    typedef struct packed {
        logic lookup;
        logic update;
    } t_cmd;

endpackage
`default_nettype wire

// ----- src/lrs_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Controller for the LRU register selector: handshakes and the two-step
// lookup/update sequence. Depends on lrs_pkg.
module lrs_ctrl (
    input  wire  logic         i_clk,
    input  wire  logic         i_rst_n,
    input  wire  logic         i_in_valid,
    output logic               o_in_stall,
    output logic               o_out_valid,
    input  wire  logic         i_out_stall,
    output lrs_pkg::t_cmd      o_cmd
);

    localparam logic ST_IDLE   = 1'b0;
    localparam logic ST_UPDATE = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_in_accept;
    logic w_out_taken;

    assign w_out_taken = r_out_valid && !i_out_stall;
    // The result register is free at the update edge whenever an item was
    // accepted, because acceptance requires it to be empty or leaving.
    assign o_in_stall  = (r_state != ST_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && !w_out_taken;
        o_cmd.lookup = 1'b0;
        o_cmd.update = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_accept) begin
                    o_cmd.lookup = 1'b1;
                    n_state      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
                n_out_valid  = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && w_in_accept) |=> (r_state == ST_UPDATE))
        else $error("accepted item not followed by an update step");

    a_no_accept_in_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> o_in_stall)
        else $error("input not stalled during update step");

    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == ST_UPDATE))
        else $error("result appeared without an update step");

    a_out_free_at_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPDATE) |-> !r_out_valid)
        else $error("update step would overwrite a pending result");

endmodule
`default_nettype wire

// ----- src/lrs_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Datapath for the LRU register selector: the recency order cells, the
// parallel lookup and the shift-to-tail update. Depends on lrs_pkg.
module lrs_datapath (
    input  wire  logic                          i_clk,
    input  wire  logic                          i_rst_n,
    input  wire  lrs_pkg::t_cmd                 i_cmd,
    input  wire  logic [lrs_pkg::OP_W-1:0]      i_opcode,
    input  wire  logic [lrs_pkg::ID_W-1:0]      i_reg_id,
    output logic       [lrs_pkg::ID_W-1:0]      o_reg_out
);

    logic [lrs_pkg::ENTRY_W-1:0] r_order [lrs_pkg::NUM_REGS];
    logic [lrs_pkg::ENTRY_W-1:0] r_pos, n_pos;
    logic [lrs_pkg::ENTRY_W-1:0] r_val, n_val;
    logic                        r_promote, n_promote;
    logic [lrs_pkg::ID_W-1:0]    r_res, n_res;

    logic [lrs_pkg::CMP_W-1:0]   w_rid_ext;
    logic [lrs_pkg::ENTRY_W-1:0] w_match_pos;
    logic                        w_found;

    assign w_rid_ext = lrs_pkg::CMP_W'(i_reg_id);

    // The order is a permutation, so at most one cell matches and the
    // position can be formed by OR-ing the matching indices.
    always_comb begin
        w_match_pos = '0;
        w_found     = 1'b0;
        for (int i = 0; i < lrs_pkg::NUM_REGS; i++) begin
            if (lrs_pkg::CMP_W'(r_order[i]) == w_rid_ext) begin
                w_found     = 1'b1;
                w_match_pos = w_match_pos | lrs_pkg::ENTRY_W'(i);
            end
        end
    end

    always_comb begin
        n_pos     = '0;
        n_val     = r_order[0];
        n_promote = 1'b0;
        n_res     = lrs_pkg::ID_W'(lrs_pkg::CMP_W'(r_order[0]));
        unique case (i_opcode)
            lrs_pkg::OP_ALLOC: begin
                n_promote = 1'b1;
            end
            lrs_pkg::OP_TOUCH: begin
                n_pos     = w_match_pos;
                n_val     = lrs_pkg::ENTRY_W'(w_rid_ext);
                n_promote = w_found;
                n_res     = i_reg_id;
            end
            default: begin
                // Peek and the unused code leave the order alone.
                n_promote = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.lookup) begin
            r_pos <= n_pos;
            r_val <= n_val;
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_promote <= 1'b0;
        end else if (i_cmd.lookup) begin
            r_promote <= n_promote;
        end
    end

    // Every cell from the chosen position up to the one before the tail takes its
    // neighbor's value, and the chosen value lands in the tail cell.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < lrs_pkg::NUM_REGS; i++) begin
                r_order[i] <= lrs_pkg::ENTRY_W'(i);
            end
        end else if (i_cmd.update && r_promote) begin
            for (int i = 0; i < lrs_pkg::NUM_REGS - 1; i++) begin
                if (i >= int'(r_pos)) begin
                    r_order[i] <= r_order[i+1];
                end
            end
            r_order[lrs_pkg::NUM_REGS-1] <= r_val;
        end
    end

    assign o_reg_out = r_res;

endmodule
`default_nettype wire

// ----- src/lru_register_selector.sv -----
`timescale 1ns / 1ps
`default_nettype none
// LRU register selector: keeps a least-recently-used order of register
// numbers and serves allocate, touch and peek requests. Uses lrs_pkg,
// lrs_ctrl and lrs_datapath.
//
// Each accepted item passes through a lookup step, which searches all order
// cells in parallel and captures the result, and then an update step, which
// shifts the cells toward the head and writes the promoted register into the
// tail. The controller stalls the input during the update step, so a new item
// is taken only after the previous one has finished its update step.
// The result sits in an output register, so the next item may be accepted in
// the same cycle the previous result is taken. Opcode 3 acts as a peek, and a
// touch of a register number outside the order returns that number unchanged.
module lru_register_selector (
    input  wire  logic                      i_clk,
    input  wire  logic                      i_rst_n,
    input  wire  logic                      i_in_valid,
    output logic                            o_in_stall,
    input  wire  logic [lrs_pkg::OP_W-1:0]  i_opcode,
    input  wire  logic [lrs_pkg::ID_W-1:0]  i_reg_id,
    output logic                            o_out_valid,
    input  wire  logic                      i_out_stall,
    output logic       [lrs_pkg::ID_W-1:0]  o_reg_out
);

    lrs_pkg::t_cmd w_cmd;

    lrs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (w_cmd)
    );

    lrs_datapath u_datapath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (w_cmd),
        .i_opcode  (i_opcode),
        .i_reg_id  (i_reg_id),
        .o_reg_out (o_reg_out)
    );

endmodule
`default_nettype wire

// ----- tb/lru_register_selector_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the LRU register selector. It drives allocate,
// touch, peek and spare-opcode items and checks each result against its own
// model of the recency order. Depends on lrs_pkg and lru_register_selector.
module lru_register_selector_tb;
    import lrs_pkg::*;

    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
    localparam int PHASE_ITEMS  = 450;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DIR_ROWS     = 18;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic            known;
        logic [ID_W-1:0] want;
    } dir_row_t;

    logic            i_clk      = 1'b0;
    logic            i_rst_n    = 1'b0;
    logic            i_in_valid = 1'b0;
    logic [OP_W-1:0] i_opcode   = '0;
    logic [ID_W-1:0] i_reg_id   = '0;
    logic            i_out_stall = 1'b0;
    logic            o_in_stall;
    logic            o_out_valid;
    logic [ID_W-1:0] o_reg_out;

    // Model of the recency order: position 0 is the least recent register.
    logic [ENTRY_W-1:0] lru_order [NUM_REGS];
    logic [ID_W-1:0]    pending_regs [$];
    dir_row_t           dir_rows [DIR_ROWS];

    int idle_pct     = 0;
    int stall_pct    = 0;
    int error_count  = 0;
    int reg_checks   = 0;
    int cycle_count  = 0;
    int alloc_count  = 0;
    int touch_count  = 0;
    int peek_count   = 0;

    lru_register_selector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_reg_id    (i_reg_id),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_reg_out   (o_reg_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Applies one item to the order model and returns the register it reports.
    function automatic logic [ID_W-1:0] lru_apply(input logic [OP_W-1:0] op,
                                                  input logic [ID_W-1:0] id);
        int                 pos;
        logic [ENTRY_W-1:0] moved;
        pos = -1;
        if (op == OP_ALLOC) begin
            pos = 0;
        end else if (op == OP_TOUCH) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                if (pos < 0 && int'(lru_order[i]) == int'(id)) pos = i;
            end
            // A register outside the order comes back unchanged.
            if (pos < 0) return id;
        end else begin
            return ID_W'(lru_order[0]);
        end
        moved = lru_order[pos];
        for (int i = pos; i + 1 < NUM_REGS; i++) lru_order[i] = lru_order[i + 1];
        lru_order[NUM_REGS - 1] = moved;
        return ID_W'(moved);
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic known, input logic [ID_W-1:0] want);
        logic [ID_W-1:0] model_reg;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            i_opcode   <= OP_W'($urandom);
            i_reg_id   <= ID_W'($urandom);
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_reg_id   <= id;
        do @(posedge i_clk); while (o_in_stall);
        model_reg = lru_apply(op, id);
        pending_regs.push_back(known ? want : model_reg);
        case (op)
            OP_ALLOC: alloc_count++;
            OP_TOUCH: touch_count++;
            default:  peek_count++;
        endcase
    endtask

    task automatic send_random(input int count);
        int              r;
        logic [OP_W-1:0] op;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(99);
            if (r < 40)      op = OP_TOUCH;
            else if (r < 75) op = OP_ALLOC;
            else if (r < 90) op = OP_PEEK;
            else             op = OP_SPARE;
            send_item(op, ID_W'($urandom_range(15)), 1'b0, '0);
        end
    endtask

    // Result side: random stall, and a check of every accepted result.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_regs.size() == 0) begin
                $display("%0t: unexpected result reg_out=%0d", $time, o_reg_out);
                error_count++;
            end else begin
                if (o_reg_out !== pending_regs[0]) begin
                    $display("%0t: reg_out mismatch, expected %0d, actual %0d",
                             $time, pending_regs[0], o_reg_out);
                    error_count++;
                end
                void'(pending_regs.pop_front());
                reg_checks++;
            end
        end
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("%0t: timeout with %0d results outstanding",
                     $time, pending_regs.size());
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        for (int i = 0; i < NUM_REGS; i++) lru_order[i] = ENTRY_W'(i);

        // Rows with a typed result are plain after reset; the rest use the model.
        dir_rows[0]  = '{OP_PEEK,  4'd9,  1'b1, 4'd0};
        dir_rows[1]  = '{OP_SPARE, 4'd15, 1'b1, 4'd0};
        dir_rows[2]  = '{OP_ALLOC, 4'd15, 1'b1, 4'd0};
        dir_rows[3]  = '{OP_ALLOC, 4'd0,  1'b1, 4'd1};
        dir_rows[4]  = '{OP_TOUCH, 4'd15, 1'b1, 4'd15};
        dir_rows[5]  = '{OP_TOUCH, 4'd15, 1'b1, 4'd15};
        dir_rows[6]  = '{OP_TOUCH, 4'd0,  1'b1, 4'd0};
        dir_rows[7]  = '{OP_TOUCH, 4'd2,  1'b1, 4'd2};
        dir_rows[8]  = '{OP_PEEK,  4'd0,  1'b0, 4'd0};
        dir_rows[9]  = '{OP_SPARE, 4'd0,  1'b0, 4'd0};
        dir_rows[10] = '{OP_ALLOC, 4'd5,  1'b0, 4'd0};
        dir_rows[11] = '{OP_TOUCH, 4'd8,  1'b1, 4'd8};
        dir_rows[12] = '{OP_TOUCH, 4'd1,  1'b1, 4'd1};
        dir_rows[13] = '{OP_ALLOC, 4'd10, 1'b0, 4'd0};
        dir_rows[14] = '{OP_TOUCH, 4'd7,  1'b1, 4'd7};
        dir_rows[15] = '{OP_ALLOC, 4'd3,  1'b0, 4'd0};
        dir_rows[16] = '{OP_PEEK,  4'd6,  1'b0, 4'd0};
        dir_rows[17] = '{OP_TOUCH, 4'd12, 1'b1, 4'd12};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            send_item(dir_rows[i].op, dir_rows[i].id, dir_rows[i].known, dir_rows[i].want);
        end
        send_random(PHASE_ITEMS);

        idle_pct  = 87;
        stall_pct = 0;
        send_random(PHASE_ITEMS);

        idle_pct  = 0;
        stall_pct = 87;
        send_random(PHASE_ITEMS);

        idle_pct  = 21;
        stall_pct = 21;
        send_random(PHASE_ITEMS);

        i_in_valid <= 1'b0;
        while (pending_regs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Checked %0d results: %0d allocates, %0d touches, %0d peeks.",
                 reg_checks, alloc_count, touch_count, peek_count);
        $display("Idle mixes: none, sender 87%%, receiver 87%%, both 21%%; %0d errors.",
                 error_count);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
